>>> hw/rtl/ecvs_pkg.sv
// Shared field widths and request mode codes for the clock victim selector.
`default_nettype none

package ecvs_pkg;

    localparam int FRAME_W = 5;
    localparam int CFG_W   = 6;

    typedef enum logic [1:0] {
        MODE_ACCESS = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

endpackage

`default_nettype wire

>>> hw/rtl/enhanced_clock_victim_select.sv
// Enhanced second-chance clock victim selector: top level.
// Access, fill and unused-mode requests get a registered result that appears the
// cycle after acceptance; they can follow back to back while m_ready is high.
// A victim select probes one frame per cycle through the RAM read port, for at
// most four sweeps of the swept count, and then registers the result.
// After reset both bit RAMs are cleared one frame at a time with s_ready low.
`default_nettype none

module enhanced_clock_victim_select #(
    parameter int MAX_FRAMES = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ecvs_pkg::CFG_W-1:0]     cfg_frames_in_use,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_mode,
    input  wire logic [ecvs_pkg::FRAME_W-1:0]   s_frame,
    input  wire logic                           s_is_write,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_victim_found,
    output logic [ecvs_pkg::FRAME_W-1:0]        m_victim_frame,
    output logic                                m_victim_dirty
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int CW = (NW > ecvs_pkg::CFG_W) ? NW : ecvs_pkg::CFG_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t                       state_reg;
    logic [ecvs_pkg::CFG_W-1:0]   fiu_reg;
    logic [AW-1:0]                hand_reg;
    logic [AW-1:0]                clr_cnt_reg;
    logic [AW-1:0]                probe_reg;
    logic [AW-1:0]                step_cnt_reg;
    logic                         pass_b_reg;
    logic                         fwd_valid_reg;
    logic                         fwd_data_reg;
    logic                         m_valid_reg;
    logic                         found_reg;
    logic [ecvs_pkg::FRAME_W-1:0] vframe_reg;
    logic                         vdirty_reg;

    logic [CW-1:0] fiu_ext;
    logic [NW-1:0] sweep_n;
    logic [AW-1:0] start_f;
    logic [AW-1:0] probe_next;
    logic [AW-1:0] rd_addr;
    logic          s_fire;
    logic          frame_ok;
    logic          use_q;
    logic          mod_q;
    logic          use_eff;
    logic          hit;
    logic          pass_end;
    logic          res_load;

    logic          use_we;
    logic [AW-1:0] use_waddr;
    logic          use_wdata;
    logic          mod_we;
    logic [AW-1:0] mod_waddr;
    logic          mod_wdata;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_victim_found = found_reg;
    assign m_victim_frame = vframe_reg;
    assign m_victim_dirty = vdirty_reg;

    // swept count: zero sweeps one frame, anything above the store is clamped
    always_comb begin
        fiu_ext = CW'(fiu_reg);
        if (fiu_ext == '0) begin
            sweep_n = NW'(1);
        end else if (fiu_ext > CW'(MAX_FRAMES)) begin
            sweep_n = NW'(MAX_FRAMES);
        end else begin
            sweep_n = NW'(fiu_ext);
        end
    end

    assign start_f    = (NW'(hand_reg) >= sweep_n) ? '0 : hand_reg;
    assign probe_next = ((NW'(probe_reg) + NW'(1)) >= sweep_n) ? '0 : probe_reg + AW'(1);
    assign rd_addr    = (state_reg == ST_SEARCH) ? probe_next : start_f;
    assign frame_ok   = (32'(s_frame) < 32'(MAX_FRAMES));

    // use bit cleared in the same cycle it is read back (single-frame sweep)
    assign use_eff  = fwd_valid_reg ? fwd_data_reg : use_q;
    assign hit      = (state_reg == ST_SEARCH) && !use_eff && (mod_q == pass_b_reg);
    assign pass_end = (NW'(step_cnt_reg) == (sweep_n - NW'(1)));

    // a new result enters the output register this cycle
    assign res_load = hit || ((state_reg == ST_IDLE) && s_fire
                              && (s_mode != ecvs_pkg::MODE_SELECT));

    always_comb begin
        use_we    = 1'b0;
        use_waddr = AW'(s_frame);
        use_wdata = 1'b1;
        mod_we    = 1'b0;
        mod_waddr = AW'(s_frame);
        mod_wdata = s_is_write;
        unique case (state_reg)
            ST_CLEAR: begin
                use_we    = 1'b1;
                use_waddr = clr_cnt_reg;
                use_wdata = 1'b0;
                mod_we    = 1'b1;
                mod_waddr = clr_cnt_reg;
                mod_wdata = 1'b0;
            end
            ST_IDLE: begin
                if (s_fire && frame_ok) begin
                    case (s_mode)
                        ecvs_pkg::MODE_ACCESS: begin
                            use_we    = 1'b1;
                            mod_we    = s_is_write;
                            mod_wdata = 1'b1;
                        end
                        ecvs_pkg::MODE_FILL: begin
                            use_we = 1'b1;
                            mod_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // second pass clears use on every frame it skips
                use_we    = !hit && pass_b_reg;
                use_waddr = probe_reg;
                use_wdata = 1'b0;
            end
            default: begin
            end
        endcase
    end

    ecvs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FRAMES)
    ) u_use_ram (
        .aclk  (aclk),
        .we    (use_we),
        .waddr (use_waddr),
        .wdata (use_wdata),
        .raddr (rd_addr),
        .rdata (use_q)
    );

    ecvs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FRAMES)
    ) u_mod_ram (
        .aclk  (aclk),
        .we    (mod_we),
        .waddr (mod_waddr),
        .wdata (mod_wdata),
        .raddr (rd_addr),
        .rdata (mod_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            fiu_reg       <= ecvs_pkg::CFG_W'(32);
            hand_reg      <= '0;
            clr_cnt_reg   <= '0;
            probe_reg     <= '0;
            step_cnt_reg  <= '0;
            pass_b_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
            fwd_data_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            vframe_reg    <= '0;
            vdirty_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                fiu_reg <= cfg_frames_in_use;
            end
            if (m_valid_reg && m_ready && !res_load) begin
                m_valid_reg <= 1'b0;
            end
            fwd_valid_reg <= use_we && (use_waddr == rd_addr);
            fwd_data_reg  <= use_wdata;

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(MAX_FRAMES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_mode == ecvs_pkg::MODE_SELECT) begin
                            probe_reg    <= start_f;
                            step_cnt_reg <= '0;
                            pass_b_reg   <= 1'b0;
                            state_reg    <= ST_SEARCH;
                        end else begin
                            m_valid_reg <= 1'b1;
                            found_reg   <= 1'b0;
                            vframe_reg  <= '0;
                            vdirty_reg  <= 1'b0;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (hit) begin
                        // a victim is always found within two rounds of passes
                        hand_reg    <= probe_next;
                        m_valid_reg <= 1'b1;
                        found_reg   <= 1'b1;
                        vframe_reg  <= ecvs_pkg::FRAME_W'(probe_reg);
                        vdirty_reg  <= pass_b_reg;
                        state_reg   <= ST_IDLE;
                    end else begin
                        probe_reg <= probe_next;
                        if (pass_end) begin
                            step_cnt_reg <= '0;
                            pass_b_reg   <= !pass_b_reg;
                        end else begin
                            step_cnt_reg <= step_cnt_reg + AW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ecvs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ecvs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
